[src/oaids_pkg.sv]
`default_nettype none
package oaids_pkg;

  // default configuration
  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DefWordBits = 32;

  // payload field widths
  localparam int unsigned OpBits     = 3;
  localparam int unsigned IndexBits  = 4;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned PosBits    = 5;
  localparam int unsigned CountBits  = 5;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT    = 3'd0,
    OP_APPEND    = 3'd1,
    OP_DEL_INDEX = 3'd2,
    OP_DEL_VALUE = 3'd3,
    OP_FIND      = 3'd4
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_MARK   = 3'd3,
    CELL_SWAP   = 3'd4
  } cell_op_e;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_cmd_t;

endpackage
`default_nettype wire

[src/oaids_req_if.sv]
`default_nettype none
interface oaids_req_if;
  import oaids_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OpBits-1:0]           op;
  logic [IndexBits-1:0]        index;
  logic signed [ValueBits-1:0] value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface
`default_nettype wire

[src/oaids_rsp_if.sv]
`default_nettype none
interface oaids_rsp_if;
  import oaids_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [StatusBits-1:0] status;
  logic [PosBits-1:0]    position;
  logic [CountBits-1:0]  count_after;

  modport source (output valid, status, position, count_after, input ready);
  modport sink   (input valid, status, position, count_after, output ready);
endinterface
`default_nettype wire

[src/oaids_cell.sv]
`default_nettype none
module oaids_cell #(
  parameter int unsigned WordBits = oaids_pkg::DefWordBits,
  parameter int unsigned IdxBits  = oaids_pkg::IndexBits,
  parameter int unsigned CntBits  = oaids_pkg::CountBits,
  parameter int unsigned Pos      = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire oaids_pkg::cell_cmd_t  cmd_i,
  input  wire logic [IdxBits-1:0]    index_i,
  input  wire logic [CntBits-1:0]    count_i,
  input  wire logic [WordBits-1:0]   word_i,
  input  wire logic [WordBits-1:0]   left_data_i,
  input  wire logic [WordBits-1:0]   right_data_i,
  input  wire logic                  left_dead_i,
  input  wire logic                  right_dead_i,
  output      logic [WordBits-1:0]   data_o,
  output      logic                  dead_o,
  output      logic                  match_o
);
  import oaids_pkg::*;

  localparam logic [IdxBits-1:0] PosIdx   = IdxBits'(Pos);
  localparam logic [CntBits-1:0] PosCnt   = CntBits'(Pos);
  localparam logic               LeftRole = 1'(Pos % 2);

  logic [WordBits-1:0] data_q, data_d;
  logic                dead_q, dead_d;

  // only entries below the count take part
  assign match_o = (data_q == word_i) && (PosCnt < count_i);

  always_comb begin
    data_d = data_q;
    dead_d = dead_q;
    unique case (cmd_i.op)
      CELL_HOLD: ;
      CELL_INSERT: begin
        if (PosIdx > index_i) begin
          data_d = left_data_i;
        end else if (PosIdx == index_i) begin
          data_d = word_i;
        end
      end
      CELL_DELETE: begin
        if (PosIdx >= index_i) begin
          data_d = right_data_i;
        end
      end
      CELL_MARK: dead_d = match_o;
      CELL_SWAP: begin
        // odd-even exchange: a live entry moves left past a dead one
        if (cmd_i.phase == LeftRole) begin
          if (dead_q && !right_dead_i) begin
            data_d = right_data_i;
            dead_d = 1'b0;
          end
        end else begin
          if (!dead_q && left_dead_i) begin
            data_d = left_data_i;
            dead_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= 1'b0;
    end else begin
      dead_q <= dead_d;
    end
  end

  assign data_o = data_q;
  assign dead_o = dead_q;

endmodule
`default_nettype wire

[src/ordered_array_insert_delete_search_core.sv]
// packed list of up to Depth signed words, held in a row of cells
//
// req_i carries op, index and value; rsp_o returns status, position and
// count_after. both are valid/ready channels, a request moves on an edge
// where valid and ready are both high.
//
// insert, append, delete at index and unknown op codes finish in the accept
// cycle: the cells from the index on shift from a neighbor at once, the response is valid
// on the next cycle. one request per cycle while responses are taken.
// delete by value and find mark matching cells in the accept cycle, then
// scan: a match line shifts one bit a cycle past the head to count matches
// and locate the first one, and for a delete by value the cells run Depth
// rounds of odd-even exchange to compact the survivors.
// req_i.ready is high only while idle and the response register is empty
// or being taken; a stalled receiver holds the response and blocks requests.
// reset empties the list and drops any pending response; the cell words
// are not cleared, slots at or above the count are never read.
`default_nettype none
module ordered_array_insert_delete_search_core #(
  parameter int unsigned Depth    = oaids_pkg::DefDepth,
  parameter int unsigned WordBits = oaids_pkg::DefWordBits
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  oaids_req_if.sink       req_i,
  oaids_rsp_if.source     rsp_o
);
  import oaids_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (CntW > IndexBits) ? CntW : IndexBits;
  localparam int unsigned StepW = $clog2(Depth);
  localparam logic [CntW-1:0]  DepthC   = CntW'(Depth);
  localparam logic [StepW-1:0] LastStep = StepW'(Depth - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [Depth-1:0]  mline_q, mline_d;
  logic [CntW-1:0]   nmatch_q, nmatch_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic              found_q, found_d;
  logic              find_q, find_d;

  // response register
  logic                  rv_q, rv_d;
  logic [StatusBits-1:0] rstat_q, rstat_d;
  logic [PosBits-1:0]    rpos_q, rpos_d;
  logic [CountBits-1:0]  rcnt_q, rcnt_d;

  // row of cells
  cell_cmd_t            cmd;
  logic [IdxW-1:0]      cell_index;
  logic [WordBits-1:0]  word;
  logic [WordBits-1:0]  data_w [Depth];
  logic [Depth-1:0]     dead_w;
  logic [Depth-1:0]     match_w;

  logic            slot_free;
  logic            accept;
  logic [IdxW-1:0] idx_ext;
  logic [IdxW-1:0] cnt_ext;
  logic            full;
  logic            hit;

  assign slot_free   = !rv_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;

  // sign extend or cut the request value to the word width
  assign word    = WordBits'(req_i.value);
  assign idx_ext = IdxW'(req_i.index);
  assign cnt_ext = IdxW'(count_q);
  assign full    = (count_q == DepthC);
  assign hit     = mline_q[0] && (CntW'(step_q) < count_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    mline_d    = mline_q;
    nmatch_d   = nmatch_q;
    pos_d      = pos_q;
    found_d    = found_q;
    find_d     = find_q;
    rv_d       = rv_q && !rsp_o.ready;
    rstat_d    = rstat_q;
    rpos_d     = rpos_q;
    rcnt_d     = rcnt_q;
    cmd.op     = CELL_HOLD;
    cmd.phase  = step_q[0];
    cell_index = idx_ext;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rstat_d = ST_OK;
          rpos_d  = '0;
          case (req_i.op) inside
            OP_INSERT: begin
              if (full) begin
                rstat_d = ST_FULL;
              end else if (idx_ext > cnt_ext) begin
                rstat_d = ST_BAD_INDEX;
              end else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            OP_APPEND: begin
              // an append is an insert at the count
              cell_index = cnt_ext;
              if (full) begin
                rstat_d = ST_FULL;
              end else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            OP_DEL_INDEX: begin
              if (idx_ext >= cnt_ext) begin
                rstat_d = ST_BAD_INDEX;
              end else begin
                cmd.op  = CELL_DELETE;
                count_d = count_q - 1'b1;
              end
            end
            OP_DEL_VALUE, OP_FIND: begin
              cmd.op   = CELL_MARK;
              mline_d  = match_w;
              step_d   = '0;
              nmatch_d = '0;
              pos_d    = '0;
              found_d  = 1'b0;
              find_d   = (req_i.op == OP_FIND);
              state_d  = S_SCAN;
            end
            default: ;
          endcase
          if (state_d == S_IDLE) begin
            rv_d   = 1'b1;
            rcnt_d = CountBits'(count_d);
          end
        end
      end
      S_SCAN: begin
        if (!find_q) begin
          cmd.op = CELL_SWAP;
        end
        mline_d = mline_q >> 1;
        step_d  = step_q + 1'b1;
        if (hit) begin
          nmatch_d = nmatch_q + 1'b1;
          if (!found_q) begin
            found_d = 1'b1;
            pos_d   = CntW'(step_q) + 1'b1;
          end
        end
        if (step_q == LastStep) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          rv_d = 1'b1;
          if (find_q) begin
            rstat_d = found_q ? ST_OK : ST_NOT_FOUND;
            rpos_d  = PosBits'(pos_q);
            rcnt_d  = CountBits'(count_q);
          end else begin
            rstat_d = (nmatch_q == '0) ? ST_NOT_FOUND : ST_OK;
            rpos_d  = '0;
            count_d = count_q - nmatch_q;
            rcnt_d  = CountBits'(count_d);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [WordBits-1:0] left_data, right_data;
    logic                left_dead, right_dead;

    // edge cells see a live entry on the left and a dead one on the right,
    // so nothing crosses the ends of the row
    if (g == 0) begin : g_first
      assign left_data = '0;
      assign left_dead = 1'b0;
    end else begin : g_inner_l
      assign left_data = data_w[g-1];
      assign left_dead = dead_w[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_data = '0;
      assign right_dead = 1'b1;
    end else begin : g_inner_r
      assign right_data = data_w[g+1];
      assign right_dead = dead_w[g+1];
    end

    oaids_cell #(
      .WordBits (WordBits),
      .IdxBits  (IdxW),
      .CntBits  (CntW),
      .Pos      (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .index_i      (cell_index),
      .count_i      (count_q),
      .word_i       (word),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .left_dead_i  (left_dead),
      .right_dead_i (right_dead),
      .data_o       (data_w[g]),
      .dead_o       (dead_w[g]),
      .match_o      (match_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      step_q  <= '0;
      rv_q    <= 1'b0;
      find_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      rv_q    <= rv_d;
      find_q  <= find_d;
      found_q <= found_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    mline_q  <= mline_d;
    nmatch_q <= nmatch_d;
    pos_q    <= pos_d;
    rstat_q  <= rstat_d;
    rpos_q   <= rpos_d;
    rcnt_q   <= rcnt_d;
  end

  assign rsp_o.valid       = rv_q;
  assign rsp_o.status      = rstat_q;
  assign rsp_o.position    = rpos_q;
  assign rsp_o.count_after = rcnt_q;

  // the list never holds more than Depth entries
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  // a request that finishes in the accept cycle leaves a response behind it
  a_quick_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (state_d == S_IDLE)) |=> rsp_o.valid)
    else $error("missing response after one-cycle request");

  // the scan ends after its last step
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && step_q == LastStep) |=> (state_q == S_DONE))
    else $error("scan did not end on its last step");

  // the count moves only on an accept or when a scan finishes
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past((accept && state_q == S_IDLE) || state_q == S_DONE))
    else $error("count changed outside an operation");

endmodule
`default_nettype wire

[test/oaids_list_checker.sv]
`timescale 1ns / 100ps
module oaids_list_checker
  import oaids_pkg::*;
#(
  parameter int unsigned Depth = DefDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  oaids_req_if req_i,
  oaids_rsp_if rsp_i,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   list_count_o,
  output int   checked_o
);

  typedef struct packed {
    status_e              status;
    logic [PosBits-1:0]   position;
    logic [CountBits-1:0] count_after;
  } list_rsp_t;

  // shadow copy of the list
  logic [ValueBits-1:0] shadow_words [Depth];
  int unsigned          shadow_count = 0;

  list_rsp_t awaited_rsp_q [$];
  list_rsp_t exp_rsp;
  int        mismatches = 0;
  int        checked    = 0;
  int        pending_r  = 0;
  int        count_r    = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending_r;
  assign list_count_o     = count_r;
  assign checked_o        = checked;

  function automatic list_rsp_t apply_list_op(input logic [OpBits-1:0]    op,
                                              input logic [IndexBits-1:0] index,
                                              input logic [ValueBits-1:0] value);
    list_rsp_t   r;
    int unsigned idx;
    int unsigned kept;
    int          i;
    r.status   = ST_OK;
    r.position = '0;
    idx        = 32'(index);
    case (op)
      OP_INSERT: begin
        if (shadow_count >= Depth) begin
          r.status = ST_FULL;
        end else if (idx > shadow_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = shadow_count; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = value;
          shadow_count++;
        end
      end
      OP_APPEND: begin
        if (shadow_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = value;
          shadow_count++;
        end
      end
      OP_DEL_INDEX: begin
        if (idx >= shadow_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      OP_DEL_VALUE: begin
        kept = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] != value) begin
            shadow_words[kept] = shadow_words[i];
            kept++;
          end
        end
        if (kept == shadow_count) r.status = ST_NOT_FOUND;
        shadow_count = kept;
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] == value) begin
            r.position = PosBits'(i + 1);
            r.status   = ST_OK;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.count_after = CountBits'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input list_rsp_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected status %0d position %0d count %0d, got %0d %0d %0d",
               $time, what, want.status, want.position, want.count_after,
               rsp_i.status, rsp_i.position, rsp_i.count_after);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      awaited_rsp_q.delete();
      pending_r <= 0;
      count_r   <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        checked++;
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("unexpected response", '0);
        end else begin
          exp_rsp = awaited_rsp_q.pop_front();
          if (rsp_i.status !== exp_rsp.status || rsp_i.position !== exp_rsp.position ||
              rsp_i.count_after !== exp_rsp.count_after) begin
            report_mismatch("response mismatch", exp_rsp);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_rsp_q.push_back(apply_list_op(req_i.op, req_i.index, req_i.value));
      end
      pending_r <= awaited_rsp_q.size();
      count_r   <= shadow_count;
    end
  end

endmodule

[test/ordered_array_insert_delete_search_core_tb.sv]
`timescale 1ns / 100ps
module ordered_array_insert_delete_search_core_tb;
  import oaids_pkg::*;

  localparam int unsigned Depth       = DefDepth;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = Depth + 4;

  // op codes the block treats as no operation
  localparam logic [OpBits-1:0] OpSpareFirst = 3'd5;
  localparam logic [OpBits-1:0] OpSpareMid   = 3'd6;
  localparam logic [OpBits-1:0] OpSpareLast  = 3'd7;

  // sequence kinds of the random part
  localparam int SeqFill  = 0;
  localparam int SeqDrain = 1;
  localparam int SeqMixed = 2;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  oaids_req_if req_if ();
  oaids_rsp_if rsp_if ();

  int mismatches;
  int pending;
  int list_hint;
  int checked;

  int op_sent [8];
  int sent_total  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  // values that often repeat, so finds and deletes by value hit
  logic [ValueBits-1:0] value_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                           32'hffff_ffff, 32'h0000_0001, 32'h0000_0005,
                                           32'h5555_5555, 32'haaaa_aaaa};

  ordered_array_insert_delete_search_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  oaids_list_checker #(
    .Depth (Depth)
  ) list_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .list_count_o     (list_hint),
    .checked_o        (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: no request or response moving for too long ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: nothing moved for %0d cycles", IdleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stalls: runs of always ready, coin flips, a fixed duty pattern
  // and mostly-stalled stretches, with a cap on the length of any stall
  initial begin : rsp_stall_pattern
    int   mode;
    int   mode_left;
    int   stall_run;
    int   phase;
    logic go;
    rsp_if.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    stall_run = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      phase = (phase + 1) % 8;
      case (mode)
        0: go = 1'b1;
        1: go = 1'($urandom_range(0, 1));
        2: go = (phase >= 3);
        default: go = ($urandom_range(0, 5) == 0);
      endcase
      if (stall_run >= 8) go = 1'b1;
      stall_run = go ? 0 : stall_run + 1;
      rsp_if.ready <= go;
    end
  end

  function automatic logic [ValueBits-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // mostly a valid position up to limit, now and then any index
  function automatic logic [IndexBits-1:0] pick_index(input int limit);
    if ($urandom_range(0, 9) == 0) return IndexBits'($urandom_range(0, 15));
    return IndexBits'($urandom_range(0, (limit > 15) ? 15 : limit));
  endfunction

  // one request, with a random gap between bursts
  task automatic send_request(input logic [OpBits-1:0]    op,
                              input logic [IndexBits-1:0] index,
                              input logic [ValueBits-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.index <= index;
    req_if.value <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    op_sent[op]++;
    sent_total++;
  endtask

  // hold off the sender until every response is back
  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [OpBits-1:0]    op;
    logic [IndexBits-1:0] index;
    logic [ValueBits-1:0] value;
    int                   kind;
    int                   seq_len;
    int                   r;
    int                   directed_items;

    foreach (op_sent[i]) op_sent[i] = 0;
    req_if.valid <= 1'b0;
    req_if.op    <= OP_INSERT;
    req_if.index <= '0;
    req_if.value <= '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: find, delete at index, delete by value, insert past the end
    send_request(OP_FIND, 4'd0, 32'h0000_0000);
    send_request(OP_DEL_INDEX, 4'd0, 32'h0000_0000);
    send_request(OP_DEL_VALUE, 4'd0, 32'h0000_0000);
    send_request(OP_INSERT, 4'd1, 32'h0000_0001);
    // value extremes, insert at front, at the end and in the middle
    send_request(OP_INSERT, 4'd0, 32'h8000_0000);
    send_request(OP_APPEND, 4'd0, 32'h7fff_ffff);
    send_request(OP_INSERT, 4'd2, 32'hffff_ffff);
    send_request(OP_INSERT, 4'd1, 32'h0000_0000);
    // adjacent duplicates, then find and delete them
    send_request(OP_APPEND, 4'd15, 32'h0000_0005);
    send_request(OP_APPEND, 4'd0, 32'h0000_0005);
    send_request(OP_APPEND, 4'd7, 32'h0000_0005);
    send_request(OP_FIND, 4'd0, 32'h0000_0005);
    send_request(OP_FIND, 4'd0, 32'hffff_ffff);
    send_request(OP_FIND, 4'd0, 32'h0000_3039);
    send_request(OP_DEL_VALUE, 4'd0, 32'h0000_0005);
    // spare op codes leave the list alone
    send_request(OpSpareFirst, 4'd15, 32'hffff_ffff);
    send_request(OpSpareMid, 4'd0, 32'h0000_0000);
    send_request(OpSpareLast, 4'd15, 32'h8000_0000);
    // delete at index out of range, at the count, last and first entry
    send_request(OP_DEL_INDEX, 4'd15, 32'h0000_0000);
    send_request(OP_DEL_INDEX, 4'd4, 32'h0000_0000);
    send_request(OP_DEL_INDEX, 4'd3, 32'h0000_0000);
    send_request(OP_DEL_INDEX, 4'd0, 32'h0000_0000);
    send_request(OP_INSERT, 4'd15, 32'h1234_5678);
    directed_items = sent_total;

    // sender pause with everything outstanding
    wait_all_results();

    // random part: fill runs grow the list, drain runs shrink it, mixed runs between
    while (sent_total < directed_items + RandomItems) begin
      kind    = ($urandom_range(0, 2) == 0) ? SeqMixed : $urandom_range(SeqFill, SeqDrain);
      seq_len = $urandom_range(4, 20);
      for (int k = 0; k < seq_len; k++) begin
        op    = OP_FIND;
        index = IndexBits'($urandom_range(0, 15));
        value = pick_value();
        case (kind)
          SeqFill: begin
            op    = ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_INSERT;
            index = pick_index(list_hint);
          end
          SeqDrain: begin
            if ($urandom_range(0, 2) == 0) begin
              op = OP_DEL_VALUE;
            end else begin
              op    = OP_DEL_INDEX;
              index = pick_index((list_hint == 0) ? 0 : list_hint - 1);
            end
          end
          default: begin
            r = $urandom_range(0, 19);
            if (r < 4) op = OP_INSERT;
            else if (r < 8) op = OP_APPEND;
            else if (r < 11) op = OP_DEL_INDEX;
            else if (r < 14) op = OP_DEL_VALUE;
            else if (r < 19) op = OP_FIND;
            else op = OpBits'($urandom_range(OpSpareFirst, OpSpareLast));
            if (op == OP_INSERT || op == OP_DEL_INDEX) index = pick_index(list_hint);
          end
        endcase
        send_request(op, index, value);
      end
      if ($urandom_range(0, 9) == 0) wait_all_results();
    end

    // drain, then give the block time to show any stray response
    wait_all_results();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests: %0d insert, %0d append, %0d delete at index,",
             sent_total, op_sent[OP_INSERT], op_sent[OP_APPEND], op_sent[OP_DEL_INDEX]);
    $display("  %0d delete by value, %0d find, %0d spare",
             op_sent[OP_DEL_VALUE], op_sent[OP_FIND],
             op_sent[OpSpareFirst] + op_sent[OpSpareMid] + op_sent[OpSpareLast]);
    $display("%0d responses checked, %0d mismatches, %0d never arrived",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
src/oaids_pkg.sv
src/oaids_req_if.sv
src/oaids_rsp_if.sv
src/oaids_cell.sv
src/ordered_array_insert_delete_search_core.sv
test/oaids_list_checker.sv
test/ordered_array_insert_delete_search_core_tb.sv
